// ----- hdl/dlr_pkg.sv -----
// Shared widths, register indexes and reset values for the DDA line rasterizer.
`default_nettype none
package dlr_pkg;

    localparam int COORD_W     = 10;  // endpoint field width
    localparam int COLOR_W     = 32;
    localparam int ADDR_W      = 12;
    localparam int CFG_W       = 7;   // frame size register width
    localparam int CFG_IDX_W   = 1;
    localparam int MAX_PIXELS  = 64;  // pixels emitted per line at most
    localparam int PIX_CNT_W   = $clog2(MAX_PIXELS);

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] FRAME_SIZE_RESET = 7'd64;

endpackage
`default_nettype wire

// ----- hdl/dlr_ifs.sv -----
// Valid/ready channel interfaces: line commands, pixel results, config writes.
`default_nettype none
interface dlr_line_if import dlr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] first_x;
    logic [COORD_W-1:0] first_y;
    logic [COORD_W-1:0] second_x;
    logic [COORD_W-1:0] second_y;
    logic [COLOR_W-1:0] line_color;

    modport source (output valid, first_x, first_y, second_x, second_y, line_color,
                    input ready);
    modport sink   (input valid, first_x, first_y, second_x, second_y, line_color,
                    output ready);
endinterface

interface dlr_pixel_if import dlr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [ADDR_W-1:0]  pixel_address;
    logic [COLOR_W-1:0] pixel_color;
    logic               in_bounds;
    logic               last_pixel;

    modport source (output valid, pixel_address, pixel_color, in_bounds, last_pixel,
                    input ready);
    modport sink   (input valid, pixel_address, pixel_color, in_bounds, last_pixel,
                    output ready);
endinterface

interface dlr_cfg_if import dlr_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- hdl/dlr_front.sv -----
// Front end: takes a line command, picks the major axis, orders endpoints, divides out the slope.
`default_nettype none
module dlr_front import dlr_pkg::*; #(
    parameter int COORD_FRAC_BITS = 4,
    parameter int SLOPE_FRAC_BITS = 16,
    localparam int MINT_W = COORD_W - COORD_FRAC_BITS,
    localparam int MI_W   = COORD_W + SLOPE_FRAC_BITS - COORD_FRAC_BITS,
    localparam int SL_W   = SLOPE_FRAC_BITS + 7,
    localparam int JOB_W  = 1 + 2 * MINT_W + MI_W + SL_W + COLOR_W
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    dlr_line_if.sink         i_line,
    input  wire              i_q_full,
    output logic             o_q_push,
    output logic [JOB_W-1:0] o_q_job
);

    localparam int DIV_N   = COORD_W + SLOPE_FRAC_BITS;  // quotient bits
    localparam int DCNT_W  = $clog2(DIV_N);
    localparam int MAG_W   = SLOPE_FRAC_BITS + 6;        // saturated magnitude

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_PUSH = 2'd2;

    logic [1:0]         r_state;
    logic [DCNT_W-1:0]  r_div_cnt;
    logic               r_y_major;
    logic [COORD_W-1:0] r_sm, r_em, r_sn, r_dmaj;
    logic               r_dmin_neg;
    logic [COLOR_W-1:0] r_color;
    logic [COORD_W-1:0] r_rem;
    logic [DIV_N-1:0]   r_quo;

    // classification of the incoming command
    logic [COORD_W-1:0] adx, ady, sm, sn, em, en, dmin_mag;
    logic               y_major;

    always_comb begin
        adx = (i_line.first_x > i_line.second_x) ? i_line.first_x - i_line.second_x
                                                 : i_line.second_x - i_line.first_x;
        ady = (i_line.first_y > i_line.second_y) ? i_line.first_y - i_line.second_y
                                                 : i_line.second_y - i_line.first_y;
        y_major = (adx >> COORD_FRAC_BITS) <= (ady >> COORD_FRAC_BITS);
        if (y_major) begin
            if (i_line.second_y < i_line.first_y) begin
                sm = i_line.second_y; sn = i_line.second_x;
                em = i_line.first_y;  en = i_line.first_x;
            end else begin
                sm = i_line.first_y;  sn = i_line.first_x;
                em = i_line.second_y; en = i_line.second_x;
            end
        end else begin
            if (i_line.second_x < i_line.first_x) begin
                sm = i_line.second_x; sn = i_line.second_y;
                em = i_line.first_x;  en = i_line.first_y;
            end else begin
                sm = i_line.first_x;  sn = i_line.first_y;
                em = i_line.second_x; en = i_line.second_y;
            end
        end
        dmin_mag = (en > sn) ? en - sn : sn - en;
    end

    // one restoring division step
    logic [COORD_W:0]   n_trial;
    logic               n_qbit;
    logic [COORD_W-1:0] n_rem;

    always_comb begin
        n_trial = {r_rem, r_quo[DIV_N-1]};
        n_qbit  = n_trial >= {1'b0, r_dmaj};
        n_rem   = n_qbit ? COORD_W'(n_trial - {1'b0, r_dmaj}) : n_trial[COORD_W-1:0];
    end

    assign i_line.ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_line.valid) begin
                        r_state    <= S_DIV;
                        r_div_cnt  <= DCNT_W'(DIV_N - 1);
                        r_y_major  <= y_major;
                        r_sm       <= sm;
                        r_em       <= em;
                        r_sn       <= sn;
                        r_dmaj     <= em - sm;
                        r_dmin_neg <= en < sn;
                        r_color    <= i_line.line_color;
                        r_rem      <= '0;
                        r_quo      <= DIV_N'(dmin_mag) << SLOPE_FRAC_BITS;
                    end
                end
                S_DIV: begin
                    r_rem     <= n_rem;
                    r_quo     <= {r_quo[DIV_N-2:0], n_qbit};
                    r_div_cnt <= r_div_cnt - 1'b1;
                    if (r_div_cnt == '0) begin
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (!i_q_full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // saturate, sign and pack the job
    logic [MAG_W-1:0]  mag;
    logic [SL_W-1:0]   slope;
    logic [MI_W-1:0]   minor_init;

    always_comb begin
        if (r_dmaj == '0) begin
            mag = '0;
        end else if (|r_quo[DIV_N-1:MAG_W]) begin
            mag = '1;
        end else begin
            mag = r_quo[MAG_W-1:0];
        end
        slope      = r_dmin_neg ? SL_W'(-{1'b0, mag}) : SL_W'({1'b0, mag});
        minor_init = MI_W'(r_sn) << (SLOPE_FRAC_BITS - COORD_FRAC_BITS);
    end

    assign o_q_push = (r_state == S_PUSH) && !i_q_full;
    assign o_q_job  = {r_y_major, r_sm[COORD_W-1:COORD_FRAC_BITS],
                       r_em[COORD_W-1:COORD_FRAC_BITS], minor_init, slope, r_color};

endmodule
`default_nettype wire

// ----- hdl/dlr_job_fifo.sv -----
// Two-entry queue of line jobs between the front end and the stepper.
`default_nettype none
module dlr_job_fifo import dlr_pkg::*; #(
    parameter int WIDTH = 8
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  wire  [WIDTH-1:0] i_data,
    output logic             o_full,
    input  wire              i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule
`default_nettype wire

// ----- hdl/dlr_back.sv -----
// Back end: steps a job one pixel per cycle unless stalled, clips, forms addresses, holds the result.
`default_nettype none
module dlr_back import dlr_pkg::*; #(
    parameter int FRAME_DIM       = 64,
    parameter int COORD_FRAC_BITS = 4,
    parameter int SLOPE_FRAC_BITS = 16,
    localparam int MINT_W = COORD_W - COORD_FRAC_BITS,
    localparam int MI_W   = COORD_W + SLOPE_FRAC_BITS - COORD_FRAC_BITS,
    localparam int SL_W   = SLOPE_FRAC_BITS + 7,
    localparam int JOB_W  = 1 + 2 * MINT_W + MI_W + SL_W + COLOR_W
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    dlr_cfg_if.sink          i_cfg,
    input  wire              i_q_empty,
    input  wire  [JOB_W-1:0] i_q_job,
    output logic             o_q_pop,
    dlr_pixel_if.source      o_pixel
);

    localparam int MP_W   = MINT_W + 1;                 // major position, start + 63 steps
    localparam int ACC_W  = SLOPE_FRAC_BITS + 14;       // sign + 13 integer bits
    localparam int MIN_W  = ACC_W - 1 - SLOPE_FRAC_BITS;
    localparam int CMP_W  = (MP_W > MIN_W) ? MP_W : MIN_W;
    localparam int DIM_W  = $clog2(FRAME_DIM + 1);
    localparam int PIX_W  = $clog2(FRAME_DIM);
    localparam int PROD_W = PIX_W + DIM_W + 1;

    logic [CFG_W-1:0] r_width, r_height;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= FRAME_SIZE_RESET;
            r_height <= FRAME_SIZE_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_FRAME_WIDTH:  r_width  <= i_cfg.data;
                REG_FRAME_HEIGHT: r_height <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // job unpack
    logic                     j_y_major;
    logic [MINT_W-1:0]        j_start, j_end;
    logic [MI_W-1:0]          j_minor;
    logic signed [SL_W-1:0]   j_slope;
    logic [COLOR_W-1:0]       j_color;

    assign {j_y_major, j_start, j_end, j_minor, j_slope, j_color} = i_q_job;

    logic                     r_busy;
    logic [MP_W-1:0]          r_pos;
    logic [MINT_W-1:0]        r_end;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [SL_W-1:0]   r_slope;
    logic                     r_y_major;
    logic [COLOR_W-1:0]       r_color;
    logic [PIX_CNT_W-1:0]     r_cnt;

    logic                     r_out_valid;
    logic [ADDR_W-1:0]        r_out_addr;
    logic [COLOR_W-1:0]       r_out_color;
    logic                     r_out_inb;
    logic                     r_out_last;

    logic advance;
    assign advance = !r_out_valid || o_pixel.ready;
    assign o_q_pop = !r_busy && !i_q_empty;

    // current pixel
    logic [DIM_W-1:0]  w, h;
    logic              minor_ok, ok, last;
    logic [MIN_W-1:0]  minor_pix;
    logic [CMP_W-1:0]  px, py;
    logic [PROD_W-1:0] addr_full;

    always_comb begin
        w = (r_width  > CFG_W'(FRAME_DIM)) ? DIM_W'(FRAME_DIM) : DIM_W'(r_width);
        h = (r_height > CFG_W'(FRAME_DIM)) ? DIM_W'(FRAME_DIM) : DIM_W'(r_height);
        // negative accumulator: only the open interval (-1, 0) truncates to pixel zero
        if (r_acc[ACC_W-1]) begin
            minor_pix = '0;
            minor_ok  = (&r_acc[ACC_W-1:SLOPE_FRAC_BITS]) && (|r_acc[SLOPE_FRAC_BITS-1:0]);
        end else begin
            minor_pix = r_acc[ACC_W-2:SLOPE_FRAC_BITS];
            minor_ok  = 1'b1;
        end
        if (r_y_major) begin
            px = CMP_W'(minor_pix);
            py = CMP_W'(r_pos);
        end else begin
            px = CMP_W'(r_pos);
            py = CMP_W'(minor_pix);
        end
        ok        = minor_ok && (px < CMP_W'(w)) && (py < CMP_W'(h));
        addr_full = PROD_W'(py[PIX_W-1:0]) * PROD_W'(w) + PROD_W'(px[PIX_W-1:0]);
        last      = (r_pos >= MP_W'(r_end)) || (r_cnt == PIX_CNT_W'(MAX_PIXELS - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_busy    <= 1'b1;
                r_pos     <= MP_W'(j_start);
                r_end     <= j_end;
                r_acc     <= ACC_W'(j_minor);
                r_slope   <= j_slope;
                r_y_major <= j_y_major;
                r_color   <= j_color;
                r_cnt     <= '0;
            end else if (r_busy && advance) begin
                r_pos <= r_pos + 1'b1;
                r_acc <= r_acc + ACC_W'(r_slope);
                r_cnt <= r_cnt + 1'b1;
                if (last) begin
                    r_busy <= 1'b0;
                end
            end

            if (r_busy && advance) begin
                r_out_valid <= 1'b1;
                r_out_addr  <= ok ? ADDR_W'(addr_full) : '0;
                r_out_color <= r_color;
                r_out_inb   <= ok;
                r_out_last  <= last;
            end else if (o_pixel.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_pixel.valid         = r_out_valid;
    assign o_pixel.pixel_address = r_out_addr;
    assign o_pixel.pixel_color   = r_out_color;
    assign o_pixel.in_bounds     = r_out_inb;
    assign o_pixel.last_pixel    = r_out_last;

endmodule
`default_nettype wire

// ----- hdl/dda_line_rasterizer.sv -----
// DDA line rasterizer top level: line command in, one pixel write per step out.
//
// Channels: i_line takes one line command (two Q6.4 endpoints and a color) per
// transfer; o_pixel gives one pixel per transfer (address y*width+x, color,
// in-bounds flag, last marker on the final pixel of the line); i_cfg writes
// the frame width (index 0) and frame height (index 1), always ready.
// The front end takes a command only while idle and holds it until its job is
// pushed into the queue; its time per command is set by the bit-serial slope
// divider (one quotient bit a cycle over COORD_W+SLOPE_FRAC_BITS bits). The
// stepper emits one pixel a cycle while the receiver takes them, and loads
// each line's job from the queue between lines (at most 64 pixels a line);
// a two-entry job queue between them lets the divider work on the next line
// while pixels stream.
// Reset: frame size 64 x 64, queue empty, no pixel pending.
// When the receiver stalls, the output register holds its pixel, the stepper
// pauses, the queue fills and then the front end stops taking commands.
`default_nettype none
module dda_line_rasterizer import dlr_pkg::*; #(
    parameter int FRAME_DIM       = 64,
    parameter int COORD_FRAC_BITS = 4,
    parameter int SLOPE_FRAC_BITS = 16
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    dlr_line_if.sink     i_line,
    dlr_cfg_if.sink      i_cfg,
    dlr_pixel_if.source  o_pixel
);

    localparam int MINT_W = COORD_W - COORD_FRAC_BITS;
    localparam int MI_W   = COORD_W + SLOPE_FRAC_BITS - COORD_FRAC_BITS;
    localparam int SL_W   = SLOPE_FRAC_BITS + 7;
    localparam int JOB_W  = 1 + 2 * MINT_W + MI_W + SL_W + COLOR_W;

    logic             q_push, q_full, q_pop, q_empty;
    logic [JOB_W-1:0] q_wr_job, q_rd_job;

    dlr_front #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS),
        .SLOPE_FRAC_BITS (SLOPE_FRAC_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_line   (i_line),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_job  (q_wr_job)
    );

    dlr_job_fifo #(
        .WIDTH (JOB_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wr_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_rd_job)
    );

    dlr_back #(
        .FRAME_DIM       (FRAME_DIM),
        .COORD_FRAC_BITS (COORD_FRAC_BITS),
        .SLOPE_FRAC_BITS (SLOPE_FRAC_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (i_cfg),
        .i_q_empty (q_empty),
        .i_q_job   (q_rd_job),
        .o_q_pop   (q_pop),
        .o_pixel   (o_pixel)
    );

endmodule
`default_nettype wire
